// ===== hdl/bgd_pkg.sv =====
// Shared types and constants for the button gesture detector.
// Holds the configuration register map, the reset values and the register bundle type.
// No dependencies.
package bgd_pkg;

    // Register map: byte address 4*index on the configuration port.
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned MS_W   = 16;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_ACTIVE_LOW   = 3'd0;
    localparam t_reg_idx REG_DEBOUNCE     = 3'd1;
    localparam t_reg_idx REG_TRIPLE_WIN   = 3'd2;
    localparam t_reg_idx REG_LONG_PRESS   = 3'd3;
    localparam t_reg_idx REG_RESET_HOLD   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic            RST_ACTIVE_LOW = 1'b1;
    localparam logic [MS_W-1:0] RST_DEBOUNCE   = 16'd35;
    localparam logic [MS_W-1:0] RST_TRIPLE_WIN = 16'd1000;
    localparam logic [MS_W-1:0] RST_LONG_PRESS = 16'd1500;
    localparam logic [MS_W-1:0] RST_RESET_HOLD = 16'd5000;

    // Configuration bundle handed from the register file to the datapath.
    typedef struct packed {
        logic            active_low;
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] triple_window_ms;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] reset_hold_ms;
    } t_cfg;

endpackage

// ===== hdl/bgd_cfg.sv =====
// Configuration register file of the button gesture detector, on an APB-style port.
// Depends on bgd_pkg for the register map, reset values and the t_cfg bundle.
module bgd_cfg
    import bgd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    // The port never waits.
    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    // Register writes keep only the low bits of each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low       <= RST_ACTIVE_LOW;
            r_cfg.debounce_ms      <= RST_DEBOUNCE;
            r_cfg.triple_window_ms <= RST_TRIPLE_WIN;
            r_cfg.long_press_ms    <= RST_LONG_PRESS;
            r_cfg.reset_hold_ms    <= RST_RESET_HOLD;
        end else if (w_wr) begin
            case (w_idx)
                REG_ACTIVE_LOW: r_cfg.active_low       <= pwdata[0];
                REG_DEBOUNCE:   r_cfg.debounce_ms      <= pwdata[MS_W-1:0];
                REG_TRIPLE_WIN: r_cfg.triple_window_ms <= pwdata[MS_W-1:0];
                REG_LONG_PRESS: r_cfg.long_press_ms    <= pwdata[MS_W-1:0];
                REG_RESET_HOLD: r_cfg.reset_hold_ms    <= pwdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer; unused addresses read as zero.
    always_comb begin
        case (w_idx)
            REG_ACTIVE_LOW: prdata = {{(DATA_W-1){1'b0}}, r_cfg.active_low};
            REG_DEBOUNCE:   prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.debounce_ms};
            REG_TRIPLE_WIN: prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.triple_window_ms};
            REG_LONG_PRESS: prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.long_press_ms};
            REG_RESET_HOLD: prdata = {{(DATA_W-MS_W){1'b0}}, r_cfg.reset_hold_ms};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/button_gesture_detector.sv =====
// Button gesture detector: debounce, triple-press sleep, long-press toggle, reset hold.
// Path: the input register, then one pass of subtract-compare logic into the result
// register.
// Throughput: one beat per cycle unless a stalled result register holds both stages.
// Reset (synchronous, active low) empties both stages, clears the gesture state and
// loads the configuration registers with their defaults. Depends on bgd_pkg and bgd_cfg.
module button_gesture_detector
    import bgd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic              i_pin_level,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_toggle_mode,
    output logic              o_sleep_request,
    output logic              o_reset_request,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;

    // Input register stage
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic              r_in_level;

    // Gesture state; the oldest history slot is only needed at the moment it is
    // shifted in, so the two newer presses are all that is kept.
    logic              r_acc_level;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_hist1;
    logic [TIME_W-1:0] r_hist2;
    logic [TIME_W-1:0] r_hold_start;
    logic              r_long_done;

    // Result register stage
    logic              r_out_valid;
    logic              r_toggle;
    logic              r_sleep;
    logic              r_reset_req;

    // Next values from the compute pass
    logic              n_acc_level;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_hist1;
    logic [TIME_W-1:0] n_hist2;
    logic [TIME_W-1:0] n_hold_start;
    logic              n_long_done;
    logic              n_toggle;
    logic              n_sleep;
    logic              n_reset_req;

    logic              w_adv;
    logic              w_pressed;
    logic              w_change;
    logic              w_held;
    logic              w_long_pre;
    logic [TIME_W-1:0] w_dt_change;
    logic [TIME_W-1:0] w_dt_hist;
    logic [TIME_W-1:0] w_dt_hold;

    bgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Both stages move whenever the result register is empty or being taken.
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;

    // Input register: loads on every cycle it is not held by a stalled result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_time  <= i_time_ms;
            r_in_level <= i_pin_level;
        end
    end

    // Debounced level change and press history; all time differences wrap.
    assign w_pressed   = w_cfg.active_low ? !r_in_level : r_in_level;
    assign w_dt_change = r_in_time - r_last_change;
    assign w_dt_hist   = r_in_time - r_hist1;
    assign w_change    = (w_pressed != r_acc_level) &&
                         (w_dt_change > {{(TIME_W-MS_W){1'b0}}, w_cfg.debounce_ms});

    always_comb begin
        n_acc_level   = r_acc_level;
        n_last_change = r_last_change;
        n_hist1       = r_hist1;
        n_hist2       = r_hist2;
        n_hold_start  = r_hold_start;
        w_long_pre    = r_long_done;
        n_sleep       = 1'b0;
        if (w_change) begin
            n_last_change = r_in_time;
            n_acc_level   = w_pressed;
            if (w_pressed) begin
                n_hold_start = r_in_time;
                w_long_pre   = 1'b0;
                n_hist1      = r_hist2;
                n_hist2      = r_in_time;
                // The oldest of three presses is the entry that shifts into slot zero.
                n_sleep      = (r_hist1 != '0) &&
                               (w_dt_hist < {{(TIME_W-MS_W){1'b0}}, w_cfg.triple_window_ms});
            end else begin
                n_hold_start = '0;
            end
        end
    end

    // Hold checks use the raw reading and the hold start after this beat's change.
    assign w_dt_hold = r_in_time - n_hold_start;
    assign w_held    = w_pressed && (n_hold_start != '0);

    always_comb begin
        n_toggle    = 1'b0;
        n_long_done = w_long_pre;
        n_reset_req = w_held &&
                      (w_dt_hold >= {{(TIME_W-MS_W){1'b0}}, w_cfg.reset_hold_ms});
        if (w_held && !w_long_pre &&
            (w_dt_hold >= {{(TIME_W-MS_W){1'b0}}, w_cfg.long_press_ms})) begin
            n_toggle    = 1'b1;
            n_long_done = 1'b1;
        end
    end

    // Gesture state commits when the beat in the input register moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_level   <= 1'b0;
            r_last_change <= '0;
            r_hist1       <= '0;
            r_hist2       <= '0;
            r_hold_start  <= '0;
            r_long_done   <= 1'b0;
        end else if (w_adv && r_in_valid) begin
            r_acc_level   <= n_acc_level;
            r_last_change <= n_last_change;
            r_hist1       <= n_hist1;
            r_hist2       <= n_hist2;
            r_hold_start  <= n_hold_start;
            r_long_done   <= n_long_done;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_toggle    <= n_toggle;
            r_sleep     <= n_sleep;
            r_reset_req <= n_reset_req;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_toggle_mode   = r_toggle;
    assign o_sleep_request = r_sleep;
    assign o_reset_request = r_reset_req;

`ifndef SYNTHESIS
    // A result beat appears only after a beat sat in the input register.
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result beat without a preceding input beat");

    // The long-press flag is only ever set together with a toggle result.
    a_long_done_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_long_done) |-> (r_out_valid && r_toggle))
        else $error("long press latched without a toggle result");

    // An accepted level change stamps the time of the beat that caused it.
    a_change_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_acc_level) |-> (r_last_change == $past(r_in_time)))
        else $error("level change without matching change time");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the button gesture detector: directed and random poll ticks.
// A small scoreboard class predicts every result beat and checks the register readbacks.
// Depends on bgd_pkg and button_gesture_detector.
module testbench;
    import bgd_pkg::*;

    // First index past the register map; writes there must change nothing.
    localparam t_reg_idx REG_SPARE = 3'd5;

    typedef struct packed {
        logic toggle_mode;
        logic sleep_request;
        logic reset_request;
    } t_gesture_flags;

    // Gesture predictor with its own copy of the registers and the gesture state.
    class gesture_scoreboard;
        logic              active_low;
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   triple_window_ms;
        logic [MS_W-1:0]   long_press_ms;
        logic [MS_W-1:0]   reset_hold_ms;
        logic              accepted_pressed;
        logic [TIME_W-1:0] last_change_ms;
        logic [TIME_W-1:0] hold_start_ms;
        logic [TIME_W-1:0] press_ms [3];
        logic              toggle_latched;
        t_gesture_flags    expected_flags_q [$];
        int unsigned       mismatches;
        int unsigned       toggles_seen;
        int unsigned       sleeps_seen;
        int unsigned       resets_seen;

        function new();
            active_low       = RST_ACTIVE_LOW;
            debounce_ms      = RST_DEBOUNCE;
            triple_window_ms = RST_TRIPLE_WIN;
            long_press_ms    = RST_LONG_PRESS;
            reset_hold_ms    = RST_RESET_HOLD;
            accepted_pressed = 1'b0;
            last_change_ms   = '0;
            hold_start_ms    = '0;
            toggle_latched   = 1'b0;
            foreach (press_ms[i]) press_ms[i] = '0;
            mismatches       = 0;
            toggles_seen     = 0;
            sleeps_seen      = 0;
            resets_seen      = 0;
        endfunction

        // Only the low bits of each register are kept; unknown indexes are ignored.
        function void set_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ACTIVE_LOW: active_low       = value[0];
                REG_DEBOUNCE:   debounce_ms      = value[MS_W-1:0];
                REG_TRIPLE_WIN: triple_window_ms = value[MS_W-1:0];
                REG_LONG_PRESS: long_press_ms    = value[MS_W-1:0];
                REG_RESET_HOLD: reset_hold_ms    = value[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(t_reg_idx idx);
            reg_value = '0;
            case (idx)
                REG_ACTIVE_LOW: reg_value[0]        = active_low;
                REG_DEBOUNCE:   reg_value[MS_W-1:0] = debounce_ms;
                REG_TRIPLE_WIN: reg_value[MS_W-1:0] = triple_window_ms;
                REG_LONG_PRESS: reg_value[MS_W-1:0] = long_press_ms;
                REG_RESET_HOLD: reg_value[MS_W-1:0] = reset_hold_ms;
                default: ;
            endcase
        endfunction

        function void report_mismatch(string what, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        // Works out the flags for one accepted poll tick and queues them.
        function void note_tick(logic [TIME_W-1:0] now, logic pin);
            logic              pressed;
            logic [TIME_W-1:0] since_change;
            logic [TIME_W-1:0] window_age;
            logic [TIME_W-1:0] held;
            t_gesture_flags    flags;
            pressed      = active_low ? ~pin : pin;
            flags        = '0;
            since_change = now - last_change_ms;
            // Debounced level change; a press shifts the three-entry history.
            if (pressed != accepted_pressed && since_change > TIME_W'(debounce_ms)) begin
                last_change_ms   = now;
                accepted_pressed = pressed;
                if (pressed) begin
                    hold_start_ms  = now;
                    toggle_latched = 1'b0;
                    press_ms[0]    = press_ms[1];
                    press_ms[1]    = press_ms[2];
                    press_ms[2]    = now;
                    window_age     = now - press_ms[0];
                    if (press_ms[0] != '0 && window_age < TIME_W'(triple_window_ms)) begin
                        flags.sleep_request = 1'b1;
                    end
                end else begin
                    hold_start_ms = '0;
                end
            end
            // Hold checks use the raw reading of this tick, not the debounced level.
            held = now - hold_start_ms;
            if (pressed && hold_start_ms != '0) begin
                if (!toggle_latched && held >= TIME_W'(long_press_ms)) begin
                    toggle_latched    = 1'b1;
                    flags.toggle_mode = 1'b1;
                end
                if (held >= TIME_W'(reset_hold_ms)) begin
                    flags.reset_request = 1'b1;
                end
            end
            expected_flags_q.push_back(flags);
        endfunction

        // Compares one result beat with the oldest predicted flags.
        function void check_flags(t_gesture_flags got);
            t_gesture_flags want;
            toggles_seen += got.toggle_mode;
            sleeps_seen  += got.sleep_request;
            resets_seen  += got.reset_request;
            if (expected_flags_q.size() == 0) begin
                report_mismatch("unexpected result beat", '0, DATA_W'(got));
                return;
            end
            want = expected_flags_q.pop_front();
            if (got.toggle_mode !== want.toggle_mode) begin
                report_mismatch("toggle_mode", DATA_W'(want.toggle_mode),
                                DATA_W'(got.toggle_mode));
            end
            if (got.sleep_request !== want.sleep_request) begin
                report_mismatch("sleep_request", DATA_W'(want.sleep_request),
                                DATA_W'(got.sleep_request));
            end
            if (got.reset_request !== want.reset_request) begin
                report_mismatch("reset_request", DATA_W'(want.reset_request),
                                DATA_W'(got.reset_request));
            end
        endfunction

        function int unsigned pending();
            return expected_flags_q.size();
        endfunction
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [TIME_W-1:0] i_time_ms       = '0;
    logic              i_pin_level     = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic              o_toggle_mode;
    logic              o_sleep_request;
    logic              o_reset_request;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [ADDR_W-1:0] paddr           = '0;
    logic [DATA_W-1:0] pwdata          = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    gesture_scoreboard gesture_board;
    int unsigned       input_gap_pct    = 11;
    int unsigned       result_stall_pct = 87;
    int unsigned       ticks_sent       = 0;
    logic [TIME_W-1:0] cursor_ms        = '0;

    button_gesture_detector u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_time_ms       (i_time_ms),
        .i_pin_level     (i_pin_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_toggle_mode   (o_toggle_mode),
        .o_sleep_request (o_sleep_request),
        .o_reset_request (o_reset_request),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 i_clk = ~i_clk;

    // Result side: check accepted beats and draw the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            gesture_board.check_flags({o_toggle_mode, o_sleep_request, o_reset_request});
        end
        i_out_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Presents one poll tick after a random gap and holds it until accepted.
    task automatic send_tick(logic [TIME_W-1:0] now, logic pin);
        while ($urandom_range(99) < input_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_time_ms   <= now;
        i_pin_level <= pin;
        do @(posedge i_clk); while (o_in_stall);
        gesture_board.note_tick(now, pin);
        ticks_sent++;
    endtask

    // Stops the input and waits until every predicted beat has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (gesture_board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        gesture_board.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(t_reg_idx idx);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== gesture_board.reg_value(idx)) begin
            gesture_board.report_mismatch("register readback", gesture_board.reg_value(idx),
                                          prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_all_regs();
        for (int i = int'(REG_ACTIVE_LOW); i <= int'(REG_RESET_HOLD); i++) begin
            check_reg(t_reg_idx'(i));
        end
    endtask

    // Writes all five registers, upper bits included, and reads them back.
    task automatic configure(logic [DATA_W-1:0] polarity, logic [DATA_W-1:0] debounce,
                             logic [DATA_W-1:0] window, logic [DATA_W-1:0] long_press,
                             logic [DATA_W-1:0] reset_hold);
        write_reg(REG_ACTIVE_LOW, polarity);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_TRIPLE_WIN, window);
        write_reg(REG_LONG_PRESS, long_press);
        write_reg(REG_RESET_HOLD, reset_hold);
        check_all_regs();
    endtask

    // Up to two chattering ticks inside the debounce window, then a settled reading.
    task automatic level_change(logic pin);
        int unsigned deb;
        deb = 32'(gesture_board.debounce_ms);
        repeat ($urandom_range(2)) begin
            cursor_ms += $urandom_range(deb);
            send_tick(cursor_ms, 1'($urandom_range(1)));
        end
        cursor_ms += deb + 1 + $urandom_range(40);
        send_tick(cursor_ms, pin);
    endtask

    // Polls a held level over roughly the given span.
    task automatic hold_level(logic pin, int unsigned span);
        int unsigned n;
        n = $urandom_range(8, 2);
        repeat (n) begin
            cursor_ms += span / n + $urandom_range(3);
            // Now and then the contact chatters in the middle of a hold.
            send_tick(cursor_ms, ($urandom_range(9) == 0) ? ~pin : pin);
        end
    endtask

    // One random gesture, shaped by the current register settings.
    task automatic run_gesture();
        logic        press_pin;
        int unsigned lp;
        int unsigned rh;
        int unsigned kind;
        int unsigned top;
        press_pin = ~gesture_board.active_low;
        lp        = 32'(gesture_board.long_press_ms);
        rh        = 32'(gesture_board.reset_hold_ms);
        kind      = $urandom_range(99);
        if (kind < 45) begin
            // One to three clicks; three quick ones aim at the sleep gesture.
            repeat ((kind < 25) ? 3 : $urandom_range(2, 1)) begin
                level_change(press_pin);
                hold_level(press_pin, $urandom_range(60));
                level_change(~press_pin);
            end
        end else if (kind < 75) begin
            // Long hold, often past both the toggle and the reset thresholds.
            top = ((lp > rh) ? lp : rh) + 300;
            level_change(press_pin);
            hold_level(press_pin, $urandom_range(top, lp / 2));
            level_change(~press_pin);
        end else begin
            // Noise: arbitrary levels and timestamps, including zero and the wrap point.
            repeat ($urandom_range(6, 1)) begin
                case ($urandom_range(5))
                    0: cursor_ms = '0;
                    1: cursor_ms = $urandom;
                    2: cursor_ms = 32'hFFFF_FFFF - $urandom_range(200);
                    default: cursor_ms += $urandom_range(gesture_board.debounce_ms + 20);
                endcase
                send_tick(cursor_ms, 1'($urandom_range(1)));
            end
        end
        // Quiet time between gestures, sometimes long enough to age out the history.
        cursor_ms += $urandom_range(2000);
    endtask

    // Main sequence: reset, directed ticks, then three randomized phases.
    initial begin
        gesture_board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_all_regs();

        // Directed ticks at the reset settings (pin level 0 means pressed).
        send_tick(32'd0, 1'b1);
        send_tick(32'd10, 1'b0);            // inside the debounce time after reset
        send_tick(32'd100, 1'b0);           // first press
        send_tick(32'd120, 1'b1);           // bounce suppresses the hold checks
        send_tick(32'd200, 1'b1);
        send_tick(32'd300, 1'b0);
        send_tick(32'd400, 1'b1);
        send_tick(32'd500, 1'b0);           // third press inside the window
        send_tick(32'd2000, 1'b0);          // long press reached
        send_tick(32'd2100, 1'b0);
        send_tick(32'd5500, 1'b0);          // reset hold reached
        send_tick(32'd5600, 1'b0);
        send_tick(32'd5700, 1'b1);
        send_tick(32'hFFFF_FFF0, 1'b0);     // press just before the wrap
        send_tick(32'd0, 1'b1);             // too soon across the wrap
        send_tick(32'h0000_0100, 1'b1);
        send_tick(32'd0, 1'b0);             // press stamped zero starts no hold
        send_tick(32'd6000, 1'b0);
        send_tick(32'd6100, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b0);
        send_tick(32'h5A5A_5A5A, 1'b0);
        send_tick(32'h5A5A_5B00, 1'b1);
        drain();

        write_reg(REG_SPARE, '1);
        configure(32'hFFFF_FFFE, 32'hA5A5_0014, 32'h5A5A_0258, 32'h0001_012C, 32'hFFFF_0384);
        cursor_ms = $urandom;
        while (ticks_sent < 450) run_gesture();
        drain();

        input_gap_pct    = 87;
        result_stall_pct = 11;
        configure(32'd1, 32'd0, 32'h0000_FFFF, 32'd0, 32'd0);
        while (ticks_sent < 900) run_gesture();
        drain();

        input_gap_pct    = 0;
        result_stall_pct = 0;
        configure(32'd0, 32'h0000_FFFF, 32'd0, 32'h0000_FFFF, 32'h0000_FFFF);
        while (ticks_sent < 1350) run_gesture();
        drain();

        $display("Sent %0d poll ticks at reset settings and three written settings, idling on",
                 ticks_sent);
        $display("either side, then none: %0d toggles, %0d sleeps, %0d resets, %0d mismatches.",
                 gesture_board.toggles_seen, gesture_board.sleeps_seen,
                 gesture_board.resets_seen, gesture_board.mismatches);
        if (gesture_board.mismatches == 0 && gesture_board.pending() == 0) begin
            $display("** button_gesture_detector: PASSED **");
        end else begin
            $display("** button_gesture_detector: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(20 * 200000);
        $display("** button_gesture_detector: FAILED **");
        $finish;
    end
endmodule
